>>> hdl/pmc_pkg.sv
// pmc_pkg: shared types and constants of the ps/2 mouse packet cursor unit
// no dependencies

`timescale 1ns / 1ps

package pmc_pkg;

  localparam int POSITION_BITS_DEFAULT = 12;
  localparam int FIELD_BITS            = 12;
  localparam int BYTE_BITS             = 8;
  localparam int BUTTON_BITS           = 3;
  localparam int SYNC_BIT              = 3;
  localparam int CFG_INDEX_BITS        = 4;
  localparam int QUEUE_DEPTH           = 2;

  localparam int CURSOR_X_RESET = 320;
  localparam int CURSOR_Y_RESET = 240;

  localparam logic [FIELD_BITS-1:0] X_LIMIT_RESET = FIELD_BITS'(639);
  localparam logic [FIELD_BITS-1:0] Y_LIMIT_RESET = FIELD_BITS'(479);

  localparam logic [CFG_INDEX_BITS-1:0] REG_X_LIMIT = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_Y_LIMIT = CFG_INDEX_BITS'(1);

  typedef struct packed {
    logic [BUTTON_BITS-1:0] buttons;
    logic [BYTE_BITS-1:0]   x_delta;
    logic [BYTE_BITS-1:0]   y_delta;
  } packet_t;

  typedef struct packed {
    logic    push;
    packet_t packet;
  } queue_push_t;

endpackage

>>> hdl/pmc_if.sv
// pmc_if: handshake channels of the ps/2 mouse packet cursor unit
// depends on pmc_pkg

`timescale 1ns / 1ps

interface pmc_byte_if
  import pmc_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface pmc_cursor_if
  import pmc_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [FIELD_BITS-1:0]  cursor_x;
  logic [FIELD_BITS-1:0]  cursor_y;
  logic [BUTTON_BITS-1:0] buttons;

  modport source (output valid, output cursor_x, output cursor_y, output buttons, input ready);
  modport sink (input valid, input cursor_x, input cursor_y, input buttons, output ready);
endinterface

interface pmc_cfg_if
  import pmc_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [FIELD_BITS-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/pmc_packet_front.sv
// pmc_packet_front: byte intake, header sync and 3-byte packet assembly
// depends on pmc_pkg and pmc_if

`timescale 1ns / 1ps

module pmc_packet_front
  import pmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  pmc_byte_if.sink          rx,
  input  logic              queue_full,
  output queue_push_t       queue_push
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_XDELTA = 3'b010,
    PH_YDELTA = 3'b100
  } phase_t;

  phase_t               phase;
  phase_t               phase_next;
  logic [BYTE_BITS-1:0] header_byte;
  logic [BYTE_BITS-1:0] x_delta_byte;
  logic                 accept;

  // only the closing byte of a packet needs queue space
  assign rx.ready = !(queue_full && (phase == PH_YDELTA));
  assign accept   = rx.valid && rx.ready;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HEADER: begin
        if (rx.data_byte[SYNC_BIT]) begin
          phase_next = PH_XDELTA;
        end
      end
      PH_XDELTA: phase_next = PH_YDELTA;
      PH_YDELTA: phase_next = PH_HEADER;
      default:   phase_next = PH_HEADER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (phase == PH_HEADER)) begin
      header_byte <= rx.data_byte;
    end
    if (accept && (phase == PH_XDELTA)) begin
      x_delta_byte <= rx.data_byte;
    end
  end

  assign queue_push.push           = accept && (phase == PH_YDELTA);
  assign queue_push.packet.buttons = header_byte[BUTTON_BITS-1:0];
  assign queue_push.packet.x_delta = x_delta_byte;
  assign queue_push.packet.y_delta = rx.data_byte;

endmodule

>>> hdl/pmc_packet_queue.sv
// pmc_packet_queue: short fifo of assembled packets between intake and cursor update
// depends on pmc_pkg

`timescale 1ns / 1ps

module pmc_packet_queue
  import pmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  queue_push_t queue_push,
  output logic        full,
  output logic        head_valid,
  output packet_t     head,
  input  logic        pop
);

  // depth is a power of two so the pointers wrap on their own
  localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  packet_t               slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [COUNT_BITS-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full       = (count == COUNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = queue_push.push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + COUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= queue_push.packet;
    end
  end

endmodule

>>> hdl/pmc_cursor_back.sv
// pmc_cursor_back: limit registers, cursor add-and-clamp and result register
// depends on pmc_pkg and pmc_if

`timescale 1ns / 1ps

module pmc_cursor_back
  import pmc_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  pmc_cfg_if.sink      cfg,
  input  logic         head_valid,
  input  packet_t      head,
  output logic         pop,
  pmc_cursor_if.source cursor
);

  localparam int SUM_BITS = POSITION_BITS + 2;

  logic [FIELD_BITS-1:0]    x_limit;
  logic [FIELD_BITS-1:0]    y_limit;
  logic [POSITION_BITS-1:0] position_x;
  logic [POSITION_BITS-1:0] position_y;
  logic [POSITION_BITS-1:0] position_x_next;
  logic [POSITION_BITS-1:0] position_y_next;
  logic [BUTTON_BITS-1:0]   buttons;
  logic                     out_valid;
  logic [POSITION_BITS-1:0] x_lim_cut;
  logic [POSITION_BITS-1:0] y_lim_cut;
  logic signed [SUM_BITS-1:0] x_sum;
  logic signed [SUM_BITS-1:0] y_sum;
  logic signed [SUM_BITS-1:0] x_lim_ext;
  logic signed [SUM_BITS-1:0] y_lim_ext;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit <= X_LIMIT_RESET;
      y_limit <= Y_LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_X_LIMIT: x_limit <= cfg.data;
        REG_Y_LIMIT: y_limit <= cfg.data;
        default:     ;
      endcase
    end
  end

  // limit cut or widened to the position width
  assign x_lim_cut = POSITION_BITS'(x_limit);
  assign y_lim_cut = POSITION_BITS'(y_limit);
  assign x_lim_ext = signed'({2'b00, x_lim_cut});
  assign y_lim_ext = signed'({2'b00, y_lim_cut});

  // y axis of the mouse points up, so its delta is subtracted
  assign x_sum = signed'({2'b00, position_x}) + SUM_BITS'(signed'(head.x_delta));
  assign y_sum = signed'({2'b00, position_y}) - SUM_BITS'(signed'(head.y_delta));

  always_comb begin
    if (x_sum < 0) begin
      position_x_next = '0;
    end else if (x_sum > x_lim_ext) begin
      position_x_next = x_lim_cut;
    end else begin
      position_x_next = x_sum[POSITION_BITS-1:0];
    end
    if (y_sum < 0) begin
      position_y_next = '0;
    end else if (y_sum > y_lim_ext) begin
      position_y_next = y_lim_cut;
    end else begin
      position_y_next = y_sum[POSITION_BITS-1:0];
    end
  end

  assign pop = head_valid && (!out_valid || cursor.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      position_x <= POSITION_BITS'(CURSOR_X_RESET);
      position_y <= POSITION_BITS'(CURSOR_Y_RESET);
    end else begin
      if (pop) begin
        out_valid  <= 1'b1;
        position_x <= position_x_next;
        position_y <= position_y_next;
      end else if (cursor.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      buttons <= head.buttons;
    end
  end

  // the kept position is also the result register
  assign cursor.valid    = out_valid;
  assign cursor.cursor_x = FIELD_BITS'(position_x);
  assign cursor.cursor_y = FIELD_BITS'(position_y);
  assign cursor.buttons  = buttons;

endmodule

>>> hdl/ps2_mouse_packet_cursor_unit.sv
// ps2_mouse_packet_cursor_unit: top level of the ps/2 mouse packet cursor unit
// depends on pmc_pkg, pmc_if, pmc_packet_front, pmc_packet_queue, pmc_cursor_back
//
//   channel  direction  carries
//   rx       in         data_byte, one raw mouse byte per transaction
//   cursor   out        cursor_x, cursor_y, buttons, one per complete packet
//   cfg      in         index, data: 0 x_limit, 1 y_limit
//
// one byte per cycle unless a closing byte is held off; a packet's result goes
// through the queue write and then the registered add-and-clamp
// rst is synchronous: cursor at 320,240, limits 639,479, waiting for a header
// a stalled cursor channel fills the two-entry packet queue, then only the
// closing byte of a packet is held off; cfg is always ready

`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_unit
  import pmc_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  pmc_byte_if.sink     rx,
  pmc_cursor_if.source cursor,
  pmc_cfg_if.sink      cfg
);

  queue_push_t queue_push;
  logic        queue_full;
  logic        head_valid;
  packet_t     head;
  logic        pop;

  pmc_packet_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .queue_full (queue_full),
    .queue_push (queue_push)
  );

  pmc_packet_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .queue_push (queue_push),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  pmc_cursor_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .cursor     (cursor)
  );

endmodule

>>> tb/ps2_mouse_packet_cursor_unit_test.sv
// ps2_mouse_packet_cursor_unit_test: self-checking bench for the mouse packet cursor unit
// drives raw bytes and limit writes, predicts every cursor result and checks each field
// depends on pmc_pkg, pmc_if and ps2_mouse_packet_cursor_unit

`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_unit_test;
  import pmc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int QUIET_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 200;
  localparam int OPENING_ROWS   = 23;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_X      = 3'b010,
    PH_Y      = 3'b100
  } packet_phase_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0]  x;
    logic [FIELD_BITS-1:0]  y;
    logic [BUTTON_BITS-1:0] btn;
  } cursor_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic                 typed;
    cursor_t              want;
  } opening_row_t;

  logic clk = 1'b0;
  logic rst;

  pmc_byte_if   rx_ch ();
  pmc_cursor_if cursor_ch ();
  pmc_cfg_if    cfg_ch ();

  ps2_mouse_packet_cursor_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .cursor (cursor_ch),
    .cfg    (cfg_ch)
  );

  // predictor state
  packet_phase_t         phase;
  logic [BYTE_BITS-1:0]  header_byte;
  logic [BYTE_BITS-1:0]  x_byte;
  logic [FIELD_BITS-1:0] pos_x;
  logic [FIELD_BITS-1:0] pos_y;
  logic [FIELD_BITS-1:0] x_lim;
  logic [FIELD_BITS-1:0] y_lim;

  cursor_t pending_cursor[$];

  int n_errors = 0;
  int n_bytes = 0;
  int n_results = 0;
  int n_limit_writes = 0;
  int quiet_cycles = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left = 0;

  // opening rows: sync loss, button codes, full-scale deltas, clamping at both ends
  opening_row_t opening_rows [OPENING_ROWS] = '{
    '{8'h00, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{8'hF7, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{8'h08, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{8'h00, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{8'h00, 1'b1, '{12'd320, 12'd240, 3'd0}},
    '{8'h0F, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{8'h7F, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{8'h80, 1'b1, '{12'd447, 12'd368, 3'd7}},
    '{8'hFF, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{8'h7F, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{8'h80, 1'b1, '{12'd574, 12'd479, 3'd7}},
    '{8'h09, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{8'h7F, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{8'h7F, 1'b1, '{12'd639, 12'd352, 3'd1}},
    '{8'h0A, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{8'h80, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{8'h7F, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{8'h0C, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{8'h80, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{8'h7F, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{8'h08, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{8'h80, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{8'h7F, 1'b1, '{12'd255, 12'd0, 3'd0}}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [FIELD_BITS-1:0] saturate(input int v, input logic [FIELD_BITS-1:0] lim);
    if (v < 0) return '0;
    if (v > int'(lim)) return lim;
    return FIELD_BITS'(v);
  endfunction

  function automatic void advance_cursor(input logic [BYTE_BITS-1:0] b, output bit done,
                                         output cursor_t res);
    done = 1'b0;
    res = '0;
    unique case (phase)
      PH_X: begin
        x_byte = b;
        phase = PH_Y;
      end
      PH_Y: begin
        phase = PH_HEADER;
        pos_x = saturate(int'(pos_x) + int'($signed(x_byte)), x_lim);
        pos_y = saturate(int'(pos_y) - int'($signed(b)), y_lim);
        res = '{pos_x, pos_y, header_byte[BUTTON_BITS-1:0]};
        done = 1'b1;
      end
      default: begin
        phase = PH_HEADER;
        if (b[SYNC_BIT]) begin
          header_byte = b;
          phase = PH_X;
        end
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    n_errors++;
  endtask

  task automatic send_byte(input logic [BYTE_BITS-1:0] b, input bit typed, input cursor_t want);
    bit done;
    cursor_t got;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    advance_cursor(b, done, got);
    if (typed) pending_cursor.push_back(want);
    else if (done) pending_cursor.push_back(got);
    rx_ch.valid     <= 1'b1;
    rx_ch.data_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained(input bit quiet);
    rx_ch.valid <= 1'b0;
    while (pending_cursor.size() != 0) @(posedge clk);
    if (quiet) repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(input logic [FIELD_BITS-1:0] xl, input logic [FIELD_BITS-1:0] yl);
    wait_drained(1'b1);
    for (int r = 0; r < 2; r++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= (r == 0) ? REG_X_LIMIT : REG_Y_LIMIT;
      cfg_ch.data  <= (r == 0) ? xl : yl;
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      if (r == 0) x_lim = xl;
      else y_lim = yl;
      n_limit_writes++;
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [BYTE_BITS-1:0] pick_delta(input int dir);
    if (dir != 0 && $urandom_range(0, 9) < 7) return (dir > 0) ? 8'h7F : 8'h80;
    return BYTE_BITS'($urandom_range(0, 255));
  endfunction

  task automatic run_phase(input logic [FIELD_BITS-1:0] xl, input logic [FIELD_BITS-1:0] yl,
                           input int packets, input int xdir, input int ydir,
                           input bit hold, input int pause_at);
    logic [BYTE_BITS-1:0] hdr;
    set_limits(xl, yl);
    if (hold) hold_ticket <= hold_ticket + 1;
    for (int k = 0; k < packets; k++) begin
      if (k == pause_at) wait_drained(1'b0);
      hdr = BYTE_BITS'($urandom_range(0, 255)) | 8'h08;
      if ($urandom_range(0, 9) == 0) begin
        // noise byte, may or may not carry the sync bit
        send_byte(BYTE_BITS'($urandom_range(0, 255)), 1'b0, '0);
      end else if ($urandom_range(0, 11) == 0) begin
        // cut-short packet, the next header lands in the y slot
        send_byte(hdr, 1'b0, '0);
        send_byte(pick_delta(xdir), 1'b0, '0);
      end else begin
        send_byte(hdr, 1'b0, '0);
        send_byte(pick_delta(xdir), 1'b0, '0);
        send_byte(pick_delta(-ydir), 1'b0, '0);
      end
    end
  endtask

  // cursor sink: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      cursor_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      cursor_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ticket != hold_served) begin
      hold_served <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      cursor_ch.ready <= 1'b0;
    end else begin
      cursor_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    cursor_t want;
    if (!rst && cursor_ch.valid && cursor_ch.ready) begin
      n_results++;
      if (pending_cursor.size() == 0) begin
        flag_mismatch("unexpected result, cursor_x", cursor_ch.cursor_x, -1);
      end else begin
        want = pending_cursor.pop_front();
        if (cursor_ch.cursor_x !== want.x) flag_mismatch("cursor_x", cursor_ch.cursor_x, want.x);
        if (cursor_ch.cursor_y !== want.y) flag_mismatch("cursor_y", cursor_ch.cursor_y, want.y);
        if (cursor_ch.buttons !== want.btn) flag_mismatch("buttons", cursor_ch.buttons, want.btn);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((rx_ch.valid && rx_ch.ready) || (cursor_ch.valid && cursor_ch.ready)
                 || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
      if (rx_ch.valid && rx_ch.ready) n_bytes <= n_bytes + 1;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    rx_ch.valid <= 1'b0;
    rx_ch.data_byte <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_X_LIMIT;
    cfg_ch.data <= '0;
    phase = PH_HEADER;
    header_byte = '0;
    x_byte = '0;
    pos_x = FIELD_BITS'(CURSOR_X_RESET);
    pos_y = FIELD_BITS'(CURSOR_Y_RESET);
    x_lim = X_LIMIT_RESET;
    y_lim = Y_LIMIT_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct = 14;
    snk_idle_pct = 74;
    for (int i = 0; i < OPENING_ROWS; i++)
      send_byte(opening_rows[i].data, opening_rows[i].typed, opening_rows[i].want);

    // position left above a lowered limit, then zero limits
    run_phase(12'd4095, 12'd4095, 40, 1, 1, 1'b0, -1);
    run_phase(12'd100, 12'd50, 15, 0, 0, 1'b0, -1);
    run_phase(12'd0, 12'd0, 15, 0, 0, 1'b0, -1);

    src_idle_pct = 74;
    snk_idle_pct = 14;
    run_phase(12'd1, 12'd1, 15, 0, 0, 1'b0, -1);
    run_phase(12'd4095, 12'd1, 15, 1, -1, 1'b0, 7);
    run_phase(FIELD_BITS'($urandom_range(1, 4095)), FIELD_BITS'($urandom_range(1, 4095)),
              15, 0, 0, 1'b0, -1);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_phase(12'd1, 12'd4095, 15, -1, 1, 1'b1, -1);
    run_phase(X_LIMIT_RESET, Y_LIMIT_RESET, 15, 0, 0, 1'b0, -1);
    run_phase(FIELD_BITS'($urandom_range(0, 4095)), FIELD_BITS'($urandom_range(0, 4095)),
              40, int'($urandom_range(0, 2)) - 1, int'($urandom_range(0, 2)) - 1, 1'b0, -1);

    wait_drained(1'b1);
    if (pending_cursor.size() != 0) flag_mismatch("results left over", pending_cursor.size(), 0);

    $display("run covered %0d mouse bytes, %0d cursor results, %0d limit writes",
             n_bytes, n_results, n_limit_writes);
    $display("idle mixes: sender-heavy, sink-heavy and none, with one long sink hold-off");
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
